### hw/rtl/mex_pkg.sv
// Package for the modular exponentiation block: widths, register indexes,
// sequencer state codes and the request/status types of the multiplier.
// No dependencies.
`default_nettype none

package mex_pkg;

    // Operand width of the datapath.
    localparam int WIDTH = 32;
    // Bit position counter width over one operand.
    localparam int BIT_W = $clog2(WIDTH);
    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = WIDTH;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 8'd1;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_BIT  = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;

    typedef logic [WIDTH-1:0] word_t;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic  start;
        word_t x;
        word_t y;
        word_t m;
    } mm_req_t;

    // Status from the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

`default_nettype wire

### hw/rtl/mex_mulmod.sv
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle.
// A modulus of zero means the product wraps at the word width.
// Depends on mex_pkg.
`default_nettype none

module mex_mulmod
    import mex_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mm_req_t    req,
    output mm_status_t      status,
    output word_t           result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BIT_W-1:0] cnt_reg, cnt_next;
    word_t            acc_reg, acc_next;
    word_t            x_reg, x_next;
    word_t            y_reg, y_next;
    word_t            m_reg, m_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    word_t            step;

    // One Horner step: acc = (2 * acc + bit * x) mod m; the sum stays below 3m.
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + (y_reg[WIDTH-1] ? {2'b00, x_reg} : '0);
        m1  = {2'b00, m_reg};
        m2  = {1'b0, m_reg, 1'b0};
        if (m_reg == '0)
        begin
            step = sum[WIDTH-1:0];
        end
        else if (sum >= m2)
        begin
            step = word_t'(sum - m2);
        end
        else if (sum >= m1)
        begin
            step = word_t'(sum - m1);
        end
        else
        begin
            step = sum[WIDTH-1:0];
        end
    end

    // Operand capture and iteration control.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (busy_reg)
        begin
            acc_next = step;
            y_next   = {y_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = BIT_W'(WIDTH - 1);
            acc_next  = '0;
            x_next    = req.x;
            y_next    = req.y;
            m_next    = req.m;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = acc_reg;

    // The accumulator stays reduced while a product is being formed.
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && m_reg != '0 && x_reg < m_reg) |-> (acc_reg < m_reg))
        else $error("multiplier accumulator not reduced");

    // A finished product always follows a run of iterations.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a run");

    // An accepted request starts a run.
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("multiplier request not taken");

endmodule

`default_nettype wire

### hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: configuration registers,
// square-and-multiply sequencer and the shared modular multiplier.
// Depends on mex_pkg and mex_mulmod.
`default_nettype none

// Each request computes base_value ^ exponent mod modulus with left-to-right
// square-and-multiply on a single bit-serial modular multiplier. The base is
// reduced first; the bit scan then steps over the leading zero bits of the
// exponent one at a time. Each exponent bit below the leading one costs one
// squaring and each set bit one multiply, a multiply following its squaring
// directly. Exponent zero answers 1 in the next cycle.
// busy is high while a request is in progress, and start is taken only when it
// is low. The result appears on power_result for exactly one cycle with done
// high; the receiver cannot stall it, so it must take it in that cycle.
// A modulus of zero makes the products wrap at 32 bits. Configuration writes
// are to be made only while the block is idle.
module modular_exponentiation
    import mex_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [WIDTH-1:0]      base_value,
    output logic                       done,
    output logic [WIDTH-1:0]           power_result,
    input  wire logic                  write_enable,
    input  wire logic [CFG_IDX_W-1:0]  reg_index,
    input  wire logic [CFG_DATA_W-1:0] write_data
);

    logic [2:0]       state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             seen_reg, seen_next;
    logic             done_reg, done_next;
    word_t            r_reg, r_next;
    word_t            base_reg, base_next;
    word_t            res_reg, res_next;
    word_t            exponent_reg;
    word_t            modulus_reg;
    word_t            one;

    mm_req_t          mm_req;
    mm_status_t       mm_status;
    word_t            mm_result;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= '0;
            modulus_reg  <= word_t'(1);
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_EXPONENT: exponent_reg <= write_data[WIDTH-1:0];
                REG_MODULUS:  modulus_reg  <= write_data[WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // One reduced by the modulus: zero for a modulus of one.
    assign one = (modulus_reg == word_t'(1)) ? '0 : word_t'(1);

    mex_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req),
        .status (mm_status),
        .result (mm_result)
    );

    // Square-and-multiply sequencer.
    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        seen_next  = seen_reg;
        done_next  = 1'b0;
        r_next     = r_reg;
        base_next  = base_reg;
        res_next   = res_reg;
        mm_req.start = 1'b0;
        mm_req.x     = r_reg;
        mm_req.y     = r_reg;
        mm_req.m     = modulus_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (exponent_reg == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = word_t'(1);
                    end
                    else
                    begin
                        // Reduce the base first: base * 1 mod m.
                        mm_req.start = 1'b1;
                        mm_req.x     = one;
                        mm_req.y     = base_value;
                        state_next   = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                if (mm_status.done)
                begin
                    base_next  = mm_result;
                    r_next     = one;
                    bit_next   = BIT_W'(WIDTH - 1);
                    seen_next  = 1'b0;
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                // Squarings before the leading one leave the running value as it is.
                if (seen_reg)
                begin
                    mm_req.start = 1'b1;
                    state_next   = ST_SQ;
                end
                else if (exponent_reg[bit_reg])
                begin
                    mm_req.start = 1'b1;
                    mm_req.y     = base_reg;
                    seen_next    = 1'b1;
                    state_next   = ST_MUL;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_SQ:
            begin
                if (mm_status.done)
                begin
                    r_next = mm_result;
                    if (exponent_reg[bit_reg])
                    begin
                        mm_req.start = 1'b1;
                        mm_req.x     = mm_result;
                        mm_req.y     = base_reg;
                        state_next   = ST_MUL;
                    end
                    else if (bit_reg == '0)
                    begin
                        done_next  = 1'b1;
                        res_next   = mm_result;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        state_next = ST_BIT;
                    end
                end
            end
            ST_MUL:
            begin
                if (mm_status.done)
                begin
                    r_next = mm_result;
                    if (bit_reg == '0)
                    begin
                        done_next  = 1'b1;
                        res_next   = mm_result;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        state_next = ST_BIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            seen_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign power_result = res_reg;

    // An exponent of zero answers one in the next cycle.
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && exponent_reg == '0) |=> (done && power_result == word_t'(1)))
        else $error("exponent zero did not give one");

    // The sequencer only issues a product to an idle multiplier.
    a_mm_free: assert property (@(posedge clk) disable iff (!rst_n)
        mm_req.start |-> !mm_status.busy)
        else $error("multiplier request while busy");

    // The reduced base is below the modulus.
    a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED && mm_status.done && modulus_reg != '0)
            |-> (mm_result < modulus_reg))
        else $error("base not reduced");

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the modular exponentiation block: it drives
// requests and register writes, predicts each power and checks every result.
// Depends on mex_pkg and the modular_exponentiation RTL.
`default_nettype none

module tb
    import mex_pkg::*;
();

    // Register indexes outside the register list; writes to them are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'h02;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    word_t                 base_value;
    logic                  done;
    word_t                 power_result;
    logic                  write_enable;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    // Local copy of the key registers, and the powers still to come back.
    word_t exponent_setting;
    word_t modulus_setting;
    word_t pending_powers[$];
    word_t oldest_power;
    int    mismatch_count = 0;
    // Sender idling: 0 never, 1 one request in four, 2 one in two.
    int    idle_odds = 0;

    modular_exponentiation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .done         (done),
        .power_result (power_result),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    always #1 clk = ~clk;

    // Product reduced by the modulus; a zero modulus wraps at the word width.
    function automatic word_t mul_reduce(input word_t a, input word_t b, input word_t m);
        logic [2*WIDTH-1:0] product;
        product = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
        if (m != 0)
        begin
            product = product % {{WIDTH{1'b0}}, m};
        end
        return product[WIDTH-1:0];
    endfunction

    // Left-to-right square-and-multiply over all exponent bits.
    function automatic word_t expected_power(input word_t b, input word_t e, input word_t m);
        word_t acc;
        word_t reduced_base;
        if (e == 0)
        begin
            return 1;
        end
        reduced_base = (m == 0) ? b : b % m;
        acc = (m == 1) ? 0 : 1;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            acc = mul_reduce(acc, acc, m);
            if (e[i])
            begin
                acc = mul_reduce(acc, reduced_base, m);
            end
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 200)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Register write; the enable then drops before the task returns, so that enables never merge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        @(negedge clk);
        write_enable <= 1'b0;
        if (idx == REG_EXPONENT)
        begin
            exponent_setting = data[WIDTH-1:0];
        end
        else if (idx == REG_MODULUS)
        begin
            modulus_setting = data[WIDTH-1:0];
        end
        @(negedge clk);
    endtask

    task automatic set_key(input word_t e, input word_t m);
        write_register(REG_EXPONENT, e);
        write_register(REG_MODULUS, m);
    endtask

    // Sends one request and records the power it should produce.
    task automatic send_base(input word_t b);
        int gap;
        if (idle_odds != 0 && $urandom_range(0, 3) < idle_odds)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        base_value <= b;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_powers.push_back(expected_power(b, exponent_setting, modulus_setting));
        @(negedge clk);
    endtask

    // Holds off new requests until every outstanding power has been checked.
    task automatic wait_until_drained();
        start <= 1'b0;
        while (pending_powers.size() != 0 || busy)
        begin
            @(negedge clk);
        end
    endtask

    function automatic word_t pick_exponent();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return 32'd65537;
            3: return $urandom_range(1, 3);
            4, 5, 6: return $urandom_range(1, 4095);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic word_t pick_modulus();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 1;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom_range(2, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Bases spread over the whole range, below, at and above the modulus.
    function automatic word_t pick_base(input word_t m);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return (m == 0) ? $urandom : $urandom % m;
            2: return $urandom_range(0, 255);
            3: return m;
            4: return m - 1;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    // Each result is compared with the oldest outstanding power.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_powers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", power_result));
            end
            else
            begin
                oldest_power = pending_powers.pop_front();
                if (power_result !== oldest_power)
                begin
                    report_mismatch($sformatf("power_result %h, expected %h",
                                              power_result, oldest_power));
                end
            end
        end
    end

    // The registers come out of reset as exponent zero, modulus one.
    task automatic test_reset_key();
        send_base(32'h0000_0000);
        send_base(32'hFFFF_FFFF);
        wait_until_drained();
    endtask

    // Exponent zero, modulus one, full-width keys, wrapping and large bases.
    task automatic test_special_keys();
        set_key(32'd0, 32'hFFFF_FFFF);
        send_base(32'h0000_0000);
        send_base(32'hFFFF_FFFF);
        wait_until_drained();
        set_key(32'd1, 32'd1);
        send_base(32'd5);
        send_base(32'hFFFF_FFFF);
        wait_until_drained();
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'h0000_0000);
        send_base(32'h0000_0001);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        wait_until_drained();
        // A zero modulus lets the products wrap at the word width.
        set_key(32'd65537, 32'd0);
        send_base(32'd3);
        send_base(32'hFFFF_FFFF);
        send_base(32'hDEAD_BEEF);
        wait_until_drained();
        set_key(32'd3, 32'd3233);
        send_base(32'd65);
        send_base(32'd3233);
        send_base(32'd5000);
        wait_until_drained();
        set_key(32'd2, 32'h8000_0000);
        send_base(32'h0001_0001);
        wait_until_drained();
    endtask

    // Writes to indexes beyond the register list must leave the key alone.
    task automatic test_unmapped_index();
        set_key(32'd5, 32'd1000003);
        write_register(REG_TOP, 32'h0000_0000);
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        send_base(32'd7);
        send_base(32'd123456789);
        wait_until_drained();
    endtask

    // Random keys in phases, with the sender idling at a random rate.
    task automatic test_random_keys(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            wait_until_drained();
            set_key(pick_exponent(), pick_modulus());
            idle_odds = $urandom_range(0, 2);
            // Exponents above 17 bits are slow, so those phases stay short.
            burst = (exponent_setting[31:17] != 0) ? $urandom_range(2, 4)
                                                    : $urandom_range(8, 30);
            if (burst > left)
            begin
                burst = left;
            end
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    wait_until_drained();
                end
                send_base(pick_base(modulus_setting));
            end
            left -= burst;
        end
        wait_until_drained();
    endtask

    // Requests follow each other with no idling at all.
    task automatic test_back_to_back(input int count);
        idle_odds = 0;
        for (int p = 0; p < 3; p++)
        begin
            set_key($urandom_range(1, 255), pick_modulus());
            for (int i = 0; i < count / 3; i++)
            begin
                send_base(pick_base(modulus_setting));
            end
            wait_until_drained();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        base_value       = '0;
        write_enable     = 1'b0;
        reg_index        = '0;
        write_data       = '0;
        exponent_setting = 0;
        modulus_setting  = 1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_key();
        test_special_keys();
        test_unmapped_index();
        test_random_keys(460);
        test_back_to_back(60);

        // Allow a full request's worth of cycles for any stray result.
        wait_until_drained();
        repeat (2300) @(negedge clk);
        if (mismatch_count == 0 && pending_powers.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #12000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
